@@ design/sorted_distinct_value_counter_core_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_distinct_value_counter_core_assert.svh
// Assertion macros used by the checker of the value counter core.
// ----------------------------------------------------------------------------
`ifndef SORTED_DISTINCT_VALUE_COUNTER_CORE_ASSERT_SVH
`define SORTED_DISTINCT_VALUE_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sdvc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdvc_pkg
// Shared constants, controller states and command/status types.
// ----------------------------------------------------------------------------
package sdvc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_update;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic item_is_end;
    logic table_empty;
    logic last_entry;
    logic out_free;
  } status_t;

endpackage

@@ design/sdvc_in_if.sv @@
// ----------------------------------------------------------------------------
// sdvc_in_if
// Input request channel: a value to count or an end-of-set marker.
// ----------------------------------------------------------------------------
interface sdvc_in_if
  import sdvc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

@@ design/sdvc_out_if.sv @@
// ----------------------------------------------------------------------------
// sdvc_out_if
// Result channel: one table entry per result, largest value first.
// ----------------------------------------------------------------------------
interface sdvc_out_if
  import sdvc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] number;
  logic [COUNT_W-1:0]        occurrences;
  logic                      last;
  logic                      empty_res;
  logic                      overflowed;

  modport source (output valid, output number, output occurrences, output last,
                  output empty_res, output overflowed, input ready);
  modport sink   (input valid, input number, input occurrences, input last,
                  input empty_res, input overflowed, output ready);
endinterface

@@ design/sorted_distinct_value_counter_core.sv @@
// ----------------------------------------------------------------------------
// sorted_distinct_value_counter_core
// Counts distinct signed values in a sorted table and reports them on demand.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: kind = data counts value, kind =
//   end reports the whole table. A data request is captured, then applied in
//   one parallel compare-and-shift over all 64 cells; in_ch.ready returns
//   high in the cycle after.
//   An end request emits one result per entry, largest value first, with last
//   set on the smallest; an empty table gives a single result with empty_res
//   set. Results leave at one per cycle through the output register while the
//   receiver never stalls. After the last result is loaded the table and
//   overflow flag are clear and in_ch accepts again, even while that result
//   still waits. If out_ch.ready is low, the result register holds and the
//   emit sweep pauses. Reset empties the table, clears overflow and drops
//   out_ch.valid.
// ----------------------------------------------------------------------------
module sorted_distinct_value_counter_core
  import sdvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sdvc_in_if.sink    in_ch,
  sdvc_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  sdvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sdvc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_ch.kind),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_number      (out_ch.number),
    .out_occurrences (out_ch.occurrences),
    .out_last        (out_ch.last),
    .out_empty_res   (out_ch.empty_res),
    .out_overflowed  (out_ch.overflowed)
  );

endmodule

@@ design/sdvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdvc_ctrl
// Controller: takes one request, runs the table update or the emit sweep.
// ----------------------------------------------------------------------------
module sdvc_ctrl
  import sdvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = status.item_is_end ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free && (status.table_empty || status.last_entry)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.do_update = 1'b0;
    cmd.emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_RUN: begin
        cmd.do_update = !status.item_is_end;
      end
      ST_EMIT: begin
        cmd.emit_load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/sdvc_datapath.sv @@
// ----------------------------------------------------------------------------
// sdvc_datapath
// Row of table cells kept in descending order, plus the result register.
// ----------------------------------------------------------------------------
module sdvc_datapath
  import sdvc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      in_kind,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_number,
  output logic [COUNT_W-1:0]        out_occurrences,
  output logic                      out_last,
  output logic                      out_empty_res,
  output logic                      out_overflowed
);

  logic                      item_kind_r;
  logic signed [VALUE_W-1:0] item_value_r;
  logic signed [VALUE_W-1:0] val_r [TABLE_DEPTH];
  logic [COUNT_W-1:0]        cnt_r [TABLE_DEPTH];
  logic [USED_W-1:0]         used_r;
  logic                      ovf_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_number_r;
  logic [COUNT_W-1:0]        out_occ_r;
  logic                      out_last_r;
  logic                      out_empty_r;
  logic                      out_ovf_r;

  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [TABLE_DEPTH-1:0] cell_ins;
  logic                   hit;
  logic                   full;
  logic                   do_insert;
  logic                   table_empty;
  logic                   last_entry;

  // Cells below used_r hold entries, largest value in cell 0. A cell marks
  // itself as an insert point when it is empty or smaller than the new value;
  // this mark is a run of zeros followed by a run of ones.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_valid[i] = (USED_W'(i) < used_r);
      cell_eq[i]    = cell_valid[i] && (val_r[i] == item_value_r);
      cell_ins[i]   = !cell_valid[i] || (val_r[i] < item_value_r);
    end
  end

  assign hit         = |cell_eq;
  assign full        = (used_r == USED_W'(TABLE_DEPTH));
  assign do_insert   = cmd.do_update && !hit && !full;
  assign table_empty = (used_r == '0);
  assign last_entry  = (used_r == USED_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind_r  <= in_kind;
      item_value_r <= in_value;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert && cell_ins[g]) begin
          val_r[g] <= item_value_r;
          cnt_r[g] <= COUNT_W'(1);
        end else if (cmd.do_update && cell_eq[g] && (cnt_r[g] != COUNT_MAX)) begin
          cnt_r[g] <= cnt_r[g] + COUNT_W'(1);
        end else if (cmd.emit_load && !table_empty) begin
          val_r[g] <= val_r[g+1];
          cnt_r[g] <= cnt_r[g+1];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_insert && cell_ins[g] && cell_ins[g-1]) begin
          val_r[g] <= val_r[g-1];
          cnt_r[g] <= cnt_r[g-1];
        end else if (do_insert && cell_ins[g]) begin
          val_r[g] <= item_value_r;
          cnt_r[g] <= COUNT_W'(1);
        end else if (cmd.do_update && cell_eq[g] && (cnt_r[g] != COUNT_MAX)) begin
          cnt_r[g] <= cnt_r[g] + COUNT_W'(1);
        end else if (cmd.emit_load && !table_empty && (g < TABLE_DEPTH - 1)) begin
          val_r[g] <= val_r[(g + 1) % TABLE_DEPTH];
          cnt_r[g] <= cnt_r[(g + 1) % TABLE_DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_insert) begin
        used_r <= used_r + USED_W'(1);
      end else if (cmd.do_update && !hit && full) begin
        ovf_r <= 1'b1;
      end else if (cmd.emit_load) begin
        if (!table_empty) begin
          used_r <= used_r - USED_W'(1);
        end
        if (table_empty || last_entry) begin
          ovf_r <= 1'b0;
        end
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      if (table_empty) begin
        out_number_r <= '0;
        out_occ_r    <= '0;
        out_last_r   <= 1'b1;
        out_empty_r  <= 1'b1;
        out_ovf_r    <= 1'b0;
      end else begin
        out_number_r <= val_r[0];
        out_occ_r    <= cnt_r[0];
        out_last_r   <= last_entry;
        out_empty_r  <= 1'b0;
        out_ovf_r    <= ovf_r;
      end
    end
  end

  assign status.item_is_end = (item_kind_r == KIND_END);
  assign status.table_empty = table_empty;
  assign status.last_entry  = last_entry;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_number      = out_number_r;
  assign out_occurrences = out_occ_r;
  assign out_last        = out_last_r;
  assign out_empty_res   = out_empty_r;
  assign out_overflowed  = out_ovf_r;

endmodule

@@ design/sdvc_checker.sv @@
// ----------------------------------------------------------------------------
// sdvc_checker
// Port-level checks on the result channel of the value counter core.
// ----------------------------------------------------------------------------
`include "sorted_distinct_value_counter_core_assert.svh"

module sdvc_checker
  import sdvc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_number,
  input logic [COUNT_W-1:0]        out_occurrences,
  input logic                      out_last,
  input logic                      out_empty_res,
  input logic                      out_overflowed
);

  // A stalled result must stay put until it is taken.
  `SDVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_number) && $stable(out_occurrences) && $stable(out_last),
    "stalled result changed")

  // The empty report is a single, final result with zeroed fields.
  `SDVC_ASSERT_NOW(a_empty_shape, clk, rst_n, out_valid && out_empty_res,
    out_last && (out_number == '0) && (out_occurrences == '0) && !out_overflowed,
    "empty result malformed")

  // Every reported table entry was seen at least once.
  `SDVC_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid && !out_empty_res,
    out_occurrences != '0, "table entry reported with zero count")

endmodule

bind sorted_distinct_value_counter_core sdvc_checker u_sdvc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_number      (out_ch.number),
  .out_occurrences (out_ch.occurrences),
  .out_last        (out_ch.last),
  .out_empty_res   (out_ch.empty_res),
  .out_overflowed  (out_ch.overflowed)
);

@@ bench/sorted_distinct_value_counter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_distinct_value_counter_core_test
// Self-checking bench for the sorted distinct value counter core. A
// scoreboard keeps its own sorted table of values and counts, predicts the
// results of every end request, and checks the results field by field in
// order. Directed corners come first, then phases for a long run of repeats
// and for a full table, then random sets paced in bursts against a stalling
// receiver.
// ----------------------------------------------------------------------------
module sorted_distinct_value_counter_core_test;
  import sdvc_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int REPEAT_RUN   = 40;

  localparam logic signed [VALUE_W-1:0] CORNER_VALUES [10] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001,
    32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
  };

  typedef struct {
    logic signed [VALUE_W-1:0] number;
    logic [COUNT_W-1:0]        occurrences;
    logic                      last;
    logic                      empty_res;
    logic                      overflowed;
  } tally_t;

  class value_table_scoreboard;
    logic signed [VALUE_W-1:0] cell_value [TABLE_DEPTH];
    logic [COUNT_W-1:0]        cell_count [TABLE_DEPTH];
    int                        cells_used;
    bit                        overflow_flag;
    tally_t                    tally_q[$];
    int                        mismatches;

    function new();
      cells_used    = 0;
      overflow_flag = 1'b0;
      mismatches    = 0;
    endfunction

    function int pending();
      return tally_q.size();
    endfunction

    function void count_value(logic signed [VALUE_W-1:0] v);
      int i;
      int pos;
      for (i = 0; i < cells_used; i++) begin
        if (cell_value[i] == v) begin
          if (cell_count[i] != COUNT_MAX) cell_count[i] = cell_count[i] + 1'b1;
          return;
        end
      end
      if (cells_used >= TABLE_DEPTH) begin
        overflow_flag = 1'b1;
        return;
      end
      pos = cells_used;
      for (i = 0; i < cells_used; i++) begin
        if (v < cell_value[i]) begin
          pos = i;
          break;
        end
      end
      for (i = cells_used; i > pos; i--) begin
        cell_value[i] = cell_value[i-1];
        cell_count[i] = cell_count[i-1];
      end
      cell_value[pos] = v;
      cell_count[pos] = 1;
      cells_used++;
    endfunction

    // The table drains largest value first and is cleared afterwards.
    function void dump_table();
      tally_t t;
      int k;
      if (cells_used == 0) begin
        t.number      = '0;
        t.occurrences = '0;
        t.last        = 1'b1;
        t.empty_res   = 1'b1;
        t.overflowed  = 1'b0;
        tally_q.push_back(t);
      end else begin
        for (k = cells_used - 1; k >= 0; k--) begin
          t.number      = cell_value[k];
          t.occurrences = cell_count[k];
          t.last        = (k == 0);
          t.empty_res   = 1'b0;
          t.overflowed  = overflow_flag;
          tally_q.push_back(t);
        end
      end
      cells_used    = 0;
      overflow_flag = 1'b0;
    endfunction

    function void note_request(logic kind, logic signed [VALUE_W-1:0] value);
      if (kind == KIND_END) dump_table();
      else count_value(value);
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("tb: mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(tally_t seen);
      tally_t want;
      if (tally_q.size() == 0) begin
        report("result with nothing pending, number", seen.number, 0);
        return;
      end
      want = tally_q.pop_front();
      if (seen.number !== want.number) report("number", seen.number, want.number);
      if (seen.occurrences !== want.occurrences)
        report("occurrences", seen.occurrences, want.occurrences);
      if (seen.last !== want.last) report("last", seen.last, want.last);
      if (seen.empty_res !== want.empty_res) report("empty_res", seen.empty_res, want.empty_res);
      if (seen.overflowed !== want.overflowed)
        report("overflowed", seen.overflowed, want.overflowed);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   burst_left;
  int   items_sent;

  value_table_scoreboard sb = new();

  sdvc_in_if  req_ch ();
  sdvc_out_if res_ch ();

  sorted_distinct_value_counter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: ready runs of random length, now and then a long one, broken by stalls.
  initial begin
    int run;
    int hold;
    res_ch.ready = 1'b0;
    forever begin
      run  = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      hold = $urandom_range(1, 5);
      repeat (run) begin
        @(negedge clk);
        res_ch.ready <= 1'b1;
      end
      repeat (hold) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tally_t seen;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen.number      = res_ch.number;
      seen.occurrences = res_ch.occurrences;
      seen.last        = res_ch.last;
      seen.empty_res   = res_ch.empty_res;
      seen.overflowed  = res_ch.overflowed;
      sb.check_result(seen);
    end
  end

  task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] value);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, value);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic paced_request(input logic kind, input logic signed [VALUE_W-1:0] value);
    send_request(kind, value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Narrow pools make repeats likely; the full range mostly gives new entries.
  function automatic logic signed [VALUE_W-1:0] random_value(input int mode);
    logic signed [VALUE_W-1:0] v;
    case (mode)
      0: v = $urandom_range(0, 15) - 8;
      1: v = $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          default: v = 32'shFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(0, 300) - 150;
    endcase
    return v;
  endfunction

  task automatic random_set();
    int style;
    int len;
    int mode;
    int i;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      len  = 0;
      mode = 0;
    end else if (style == 1) begin
      len  = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 8);
      mode = 1;
    end else begin
      len  = $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
    end
    for (i = 0; i < len; i++) begin
      if (style != 1 && $urandom_range(0, 5) == 0) paced_request(KIND_DATA, random_value(2));
      else paced_request(KIND_DATA, random_value(mode));
    end
    paced_request(KIND_END, $urandom());
    items_sent += len + 1;
  endtask

  initial begin
    int i;
    int p;
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_DATA;
    req_ch.value = '0;
    burst_left   = 0;
    items_sent   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // An end request on an empty table, then the value corners with repeats.
    send_request(KIND_END, 32'sh7FFF_FFFF);
    wait_drained();
    for (i = 0; i < 10; i++) send_request(KIND_DATA, CORNER_VALUES[i]);
    send_request(KIND_END, 32'sh0000_0000);
    send_request(KIND_DATA, 32'sd42);
    send_request(KIND_END, 32'shFFFF_FFFF);
    send_request(KIND_END, 32'sh0000_0000);
    wait_drained();

    // Drive one value through a long run of repeats with no gaps.
    send_request(KIND_DATA, -32'sd5);
    for (i = 0; i < REPEAT_RUN; i++) send_request(KIND_DATA, 32'sh1234_5678);
    send_request(KIND_DATA, -32'sd5);
    send_request(KIND_END, $urandom());
    wait_drained();

    // Fill the table in scrambled order, bump a held value, then drop a new one.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      p = (i * 37) % TABLE_DEPTH;
      paced_request(KIND_DATA, (p - 32) * 1000003);
    end
    paced_request(KIND_DATA, -32 * 1000003);
    paced_request(KIND_DATA, 32'sd7);
    paced_request(KIND_END, $urandom());
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) wait_drained();
      random_set();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sdvc_pkg.sv
design/sdvc_in_if.sv
design/sdvc_out_if.sv
design/sdvc_ctrl.sv
design/sdvc_datapath.sv
design/sorted_distinct_value_counter_core.sv
design/sdvc_checker.sv
bench/sorted_distinct_value_counter_core_test.sv
